FILE: hdl/dq_pkg.sv
// Shared types and codes for the double-ended queue.
package dq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int WORD_W    = 32;

	localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [2:0] KIND_DROP_FRONT = 3'd2;
	localparam logic [2:0] KIND_DROP_BACK  = 3'd3;
	localparam logic [2:0] KIND_DUMP       = 3'd4;

	localparam logic [2:0] ST_DONE    = 3'd0;
	localparam logic [2:0] ST_ELEMENT = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_CLIPPED = 3'd3;
	localparam logic [2:0] ST_EMPTY   = 3'd4;

	typedef struct packed {
		logic [2:0]               kind;
		logic signed [WORD_W-1:0] value;
		logic [6:0]               count;
	} in_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] value_res;
		logic [2:0]               status;
		logic                     last;
	} out_t;

	// per-cell controls: shift toward back, shift toward front, load pushed word
	typedef struct packed {
		logic shr;
		logic shl;
		logic ld;
	} cell_ctl_t;

endpackage

FILE: hdl/double_ended_queue.sv
// Double-ended queue of signed words kept in a chain of shifting cells.
//
// Input channel in_valid/in_stall/in_word carries one operation word:
// push front, push back, drop front, drop back or dump back to front.
// Output channel out_valid/out_stall/out_word returns results through a
// single output register. Cell 0 always holds the front word.
// Push, drop back, dump of an empty queue and unknown kinds: one result,
// registered in the cycle after acceptance; the next word is taken the
// following cycle unless out_stall holds it: one word per cycle.
// Drop front of n words: the status result is registered on acceptance,
// and the chain then shifts one place per cycle; the input is blocked
// until it has shifted n places (n clipped to the stored count).
// Dump of k words: k results back to front, one per cycle while out_stall
// is low, the last one flagged; the input waits until it is registered.
// The output register holds while out_stall is high; work that needs the
// register waits, and in_stall is raised whenever it cannot take a result.
// Reset empties the queue (front at cell 0, count zero) and clears the
// output valid; cell contents are don't-care until written.
module double_ended_queue #(
	parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  dq_pkg::in_t  in_word,
	output logic         out_valid,
	input  logic         out_stall,
	output dq_pkg::out_t out_word
);
	import dq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SHIFT = 3'b010,
		S_DUMP  = 3'b100
	} state_t;

	state_t                   state_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            shift_q;
	logic [IW-1:0]            idx_q;
	logic                     out_valid_q;
	out_t                     out_q;

	logic                     slot_free;
	logic                     accept;
	logic                     full;
	logic                     clip;
	logic [CW-1:0]            drop_n;
	logic [2:0]               res_status;
	logic                     dump_go;
	logic                     emit;
	cell_ctl_t                cell_ctl  [DEPTH];
	logic signed [WORD_W-1:0] cell_data [DEPTH];

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE) || !slot_free;
	assign accept    = in_valid && !in_stall;
	assign full      = (count_q == FULL_CNT);
	assign clip      = (8'(in_word.count) > 8'(count_q));
	assign drop_n    = clip ? count_q : CW'(in_word.count);
	assign dump_go   = accept && (in_word.kind == KIND_DUMP) && (count_q != '0);
	assign emit      = (state_q == S_DUMP) && slot_free;

	always_comb begin
		res_status = ST_DONE;
		case (in_word.kind)
			KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
				if (full) res_status = ST_FULL;
			end
			KIND_DROP_FRONT, KIND_DROP_BACK: begin
				if (clip) res_status = ST_CLIPPED;
			end
			KIND_DUMP: begin
				if (count_q == '0) res_status = ST_EMPTY;
			end
			default: res_status = ST_DONE;
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [WORD_W-1:0] left_w;
		logic signed [WORD_W-1:0] right_w;

		if (i == 0) begin : g_head
			assign left_w = in_word.value;
		end else begin : g_body
			assign left_w = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_w = '0;
		end else begin : g_mid
			assign right_w = cell_data[i+1];
		end

		assign cell_ctl[i].shr = accept && (in_word.kind == KIND_PUSH_FRONT) && !full;
		assign cell_ctl[i].shl = (state_q == S_SHIFT);
		assign cell_ctl[i].ld  = accept && (in_word.kind == KIND_PUSH_BACK) && !full
			&& (count_q == CW'(i));

		dq_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[i]),
			.push_value (in_word.value),
			.left       (left_w),
			.right      (right_w),
			.data       (cell_data[i])
		);
	end

	// control: queue count, front shifting and dump walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			shift_q <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (in_word.kind)
							KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
								if (!full) count_q <= count_q + CW'(1);
							end
							KIND_DROP_FRONT: begin
								count_q <= count_q - drop_n;
								shift_q <= drop_n;
								if (drop_n != '0) state_q <= S_SHIFT;
							end
							KIND_DROP_BACK: begin
								count_q <= count_q - drop_n;
							end
							KIND_DUMP: begin
								if (dump_go) begin
									idx_q   <= IW'(count_q - CW'(1));
									state_q <= S_DUMP;
								end
							end
							default: ;
						endcase
					end
				end
				S_SHIFT: begin
					shift_q <= shift_q - CW'(1);
					if (shift_q == CW'(1)) state_q <= S_IDLE;
				end
				S_DUMP: begin
					if (emit) begin
						idx_q <= idx_q - IW'(1);
						if (idx_q == '0) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && !dump_go) || emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.value_res <= cell_data[idx_q];
			out_q.status    <= ST_ELEMENT;
			out_q.last      <= (idx_q == '0);
		end else if (accept && !dump_go) begin
			out_q.value_res <= '0;
			out_q.status    <= res_status;
			out_q.last      <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

FILE: hdl/dq_cell.sv
// One storage cell of the queue chain; takes a word from either neighbor or the input.
module dq_cell (
	input  logic                              clk,
	input  dq_pkg::cell_ctl_t                 ctl,
	input  logic signed [dq_pkg::WORD_W-1:0]  push_value,
	input  logic signed [dq_pkg::WORD_W-1:0]  left,
	input  logic signed [dq_pkg::WORD_W-1:0]  right,
	output logic signed [dq_pkg::WORD_W-1:0]  data
);
	import dq_pkg::*;

	logic signed [WORD_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.ld) begin
			data_q <= push_value;
		end else if (ctl.shr) begin
			data_q <= left;
		end else if (ctl.shl) begin
			data_q <= right;
		end
	end

	assign data = data_q;

endmodule

FILE: hdl/dq_check.sv
// Port-level checks for the double-ended queue, bound to the top level.
module dq_check (
	input logic         clk,
	input logic         arst_n,
	input logic         in_valid,
	input logic         in_stall,
	input logic         out_valid,
	input logic         out_stall,
	input dq_pkg::out_t out_word
);
	import dq_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_word)))
		else $error("result word changed while stalled");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.status != ST_ELEMENT) |-> (out_word.last
			&& out_word.value_res == '0))
		else $error("status result not final or carries data");

	a_dump_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && out_valid && out_word.status == ST_ELEMENT && !out_word.last)
			|-> in_stall)
		else $error("input taken in the middle of a dump");

	a_dump_stream: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && out_word.status == ST_ELEMENT && !out_word.last)
			|=> (out_valid && out_word.status == ST_ELEMENT))
		else $error("gap in dump stream");

endmodule

bind double_ended_queue dq_check u_dq_check (.*);
